### sv/obstacle_avoidance_drive_controller_macros.svh
// assertion macros for the obstacle avoidance drive controller
// expects i_clk and i_rst_n in the scope of use; no other dependencies
`ifndef OBSTACLE_AVOIDANCE_DRIVE_CONTROLLER_MACROS_SVH
`define OBSTACLE_AVOIDANCE_DRIVE_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define OADC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define OADC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/oadc_pkg.sv
// shared types, codes and the speed table of the drive controller
// no dependencies
`timescale 1ns / 1ps

package oadc_pkg;

    // register indexes
    localparam logic [2:0] REG_SPEED_LEVEL  = 3'd0;
    localparam logic [2:0] REG_FRONT_THRESH = 3'd1;
    localparam logic [2:0] REG_SIDE_THRESH  = 3'd2;
    localparam logic [2:0] REG_STOP_TICKS   = 3'd3;
    localparam logic [2:0] REG_REV_TICKS    = 3'd4;
    localparam logic [2:0] REG_TURN_TICKS   = 3'd5;

    // phase codes
    localparam logic [2:0] PH_CRUISE = 3'd0;
    localparam logic [2:0] PH_STOP   = 3'd1;
    localparam logic [2:0] PH_REAR   = 3'd2;
    localparam logic [2:0] PH_REV    = 3'd3;
    localparam logic [2:0] PH_CHOOSE = 3'd4;
    localparam logic [2:0] PH_LEFT   = 3'd5;
    localparam logic [2:0] PH_RIGHT  = 3'd6;

    // drive pin patterns
    localparam logic [3:0] PINS_OFF   = 4'h0;
    localparam logic [3:0] PINS_FWD   = 4'h3;
    localparam logic [3:0] PINS_REV   = 4'hC;
    localparam logic [3:0] PINS_LEFT  = 4'h9;
    localparam logic [3:0] PINS_RIGHT = 4'h6;

    // configuration register file contents
    typedef struct packed {
        logic [2:0] speed_level;
        logic [9:0] front_threshold;
        logic [9:0] side_threshold;
        logic [3:0] stop_ticks;
        logic [3:0] reverse_ticks;
        logic [3:0] turn_ticks;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] drive_pins;
        logic [7:0] left_duty;
        logic [7:0] right_duty;
    } t_result;

    // duty pair for a speed level, right duty in the upper byte
    function automatic logic [15:0] speed_duty(input logic [2:0] lvl);
        logic [15:0] d;
        case (lvl)
            3'd1:    d = {8'd210, 8'd170};
            3'd2:    d = {8'd219, 8'd177};
            3'd3:    d = {8'd225, 8'd207};
            3'd4:    d = {8'd240, 8'd194};
            3'd5:    d = {8'd255, 8'd207};
            default: d = 16'd0;
        endcase
        return d;
    endfunction

endpackage

### sv/oadc_cfg_regs.sv
// configuration register file of the drive controller
// depends on oadc_pkg
`timescale 1ns / 1ps

module oadc_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  logic [2:0]         i_index,
    input  logic [9:0]         i_data,
    output oadc_pkg::t_cfg     o_cfg
);
    import oadc_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_level     <= 3'd3;
            r_cfg.front_threshold <= 10'd500;
            r_cfg.side_threshold  <= 10'd510;
            r_cfg.stop_ticks      <= 4'd7;
            r_cfg.reverse_ticks   <= 4'd7;
            r_cfg.turn_ticks      <= 4'd5;
        end else if (i_wr) begin
            case (i_index)
                REG_SPEED_LEVEL:  r_cfg.speed_level     <= i_data[2:0];
                REG_FRONT_THRESH: r_cfg.front_threshold <= i_data;
                REG_SIDE_THRESH:  r_cfg.side_threshold  <= i_data;
                REG_STOP_TICKS:   r_cfg.stop_ticks      <= i_data[3:0];
                REG_REV_TICKS:    r_cfg.reverse_ticks   <= i_data[3:0];
                REG_TURN_TICKS:   r_cfg.turn_ticks      <= i_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/oadc_fsm.sv
// drive phase sequencer: state registers and per-tick next-state logic
// depends on oadc_pkg
`timescale 1ns / 1ps

module oadc_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  oadc_pkg::t_cfg      i_cfg,
    input  logic [9:0]          i_front,
    input  logic [9:0]          i_rear,
    input  logic [9:0]          i_left,
    input  logic [9:0]          i_right,
    output oadc_pkg::t_result   o_next
);
    import oadc_pkg::*;

    logic [2:0]  r_phase,   n_phase;
    logic [3:0]  r_count,   n_count;
    logic        r_motors,  n_motors;
    logic        r_fwd_set, n_fwd_set;
    logic [3:0]  r_pins,    n_pins;
    logic [15:0] r_duty,    n_duty;

    logic [3:0]  cnt_inc;
    logic [3:0]  limit;
    logic        hit;
    logic        rear_clear;
    logic [15:0] start_duty;

    // tick counter against the limit of the current phase
    always_comb begin
        case (r_phase)
            PH_STOP:         limit = i_cfg.stop_ticks;
            PH_REV:          limit = i_cfg.reverse_ticks;
            default:         limit = i_cfg.turn_ticks;
        endcase
        cnt_inc = r_count + 4'd1;
        hit     = (cnt_inc == limit);
    end

    assign rear_clear = (i_rear < i_cfg.front_threshold);
    // motor start keeps the old duties when the speed level is out of range
    assign start_duty = (i_cfg.speed_level inside {[3'd1:3'd5]})
                        ? speed_duty(i_cfg.speed_level) : r_duty;

    // next state for one tick
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_motors  = r_motors;
        n_fwd_set = r_fwd_set;
        n_pins    = r_pins;
        n_duty    = r_duty;
        case (r_phase)
            PH_STOP: begin
                n_count = hit ? 4'd0 : cnt_inc;
                if (hit) n_phase = PH_REAR;
            end
            PH_REAR: begin
                if (rear_clear) begin
                    n_duty   = start_duty;
                    n_motors = 1'b1;
                    n_pins   = PINS_REV;
                    n_phase  = PH_REV;
                end else begin
                    n_phase = PH_CHOOSE;
                end
            end
            PH_REV: begin
                if (rear_clear) begin
                    n_count = hit ? 4'd0 : cnt_inc;
                    if (hit) n_phase = PH_CHOOSE;
                end else begin
                    n_count = 4'd0;
                    n_phase = PH_CHOOSE;
                end
            end
            PH_CHOOSE: begin
                if (i_left <= i_right && i_left < i_cfg.side_threshold) begin
                    n_pins  = PINS_LEFT;
                    n_phase = PH_LEFT;
                end else if (i_right < i_cfg.side_threshold) begin
                    n_pins  = PINS_RIGHT;
                    n_phase = PH_RIGHT;
                end else begin
                    n_phase = PH_CRUISE;
                end
            end
            PH_LEFT, PH_RIGHT: begin
                n_count = hit ? 4'd0 : cnt_inc;
                if (hit) n_phase = PH_CRUISE;
            end
            default: begin
                // cruise, and the unused code behaves the same
                n_phase = PH_CRUISE;
                if (i_front < i_cfg.front_threshold) begin
                    if (!r_motors) begin
                        n_duty   = start_duty;
                        n_motors = 1'b1;
                    end
                    if (!r_fwd_set) begin
                        n_pins    = PINS_FWD;
                        n_fwd_set = 1'b1;
                    end
                end else begin
                    n_duty    = 16'd0;
                    n_pins    = PINS_OFF;
                    n_motors  = 1'b0;
                    n_fwd_set = 1'b0;
                    n_phase   = PH_STOP;
                end
            end
        endcase
    end

    // state update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CRUISE;
            r_count   <= 4'd0;
            r_motors  <= 1'b0;
            r_fwd_set <= 1'b0;
            r_pins    <= PINS_OFF;
            r_duty    <= 16'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_motors  <= n_motors;
            r_fwd_set <= n_fwd_set;
            r_pins    <= n_pins;
            r_duty    <= n_duty;
        end
    end

    assign o_next.phase      = n_phase;
    assign o_next.drive_pins = n_pins;
    assign o_next.right_duty = n_duty[15:8];
    assign o_next.left_duty  = n_duty[7:0];

endmodule

### sv/obstacle_avoidance_drive_controller.sv
// Obstacle avoidance drive controller. Each input transfer is one sensor tick
// with four distance samples; each tick yields exactly one result transfer with
// the motor duties, drive pins and phase after that tick. One tick is taken
// every clock cycle unless the output stalls: the phase sequencer updates its
// state at the input transfer and the result sits in a single output register,
// valid in the cycle after the input transfer; the input stays ready while the
// output register is empty or being drained in the same cycle. Configuration
// writes are always accepted and should be made while no result is pending.
// depends on oadc_pkg, oadc_cfg_regs, oadc_fsm and the assertion macro header
`timescale 1ns / 1ps
`include "obstacle_avoidance_drive_controller_macros.svh"

module obstacle_avoidance_drive_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sensor tick in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // front[9:0], rear[19:10], left[29:20], right[39:30]
    // drive result out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // right_duty[7:0], left_duty[15:8],
                                          // drive_pins[19:16], phase[22:20], zero[23]
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import oadc_pkg::*;

    t_cfg    cfg;
    t_result next_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_xfer;
    logic    out_xfer;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer        = r_out_valid && i_m_axis_tready;

    oadc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    oadc_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_xfer),
        .i_cfg   (cfg),
        .i_front (i_s_axis_tdata[9:0]),
        .i_rear  (i_s_axis_tdata[19:10]),
        .i_left  (i_s_axis_tdata[29:20]),
        .i_right (i_s_axis_tdata[39:30]),
        .o_next  (next_res)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= next_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_res.phase, r_res.drive_pins,
                              r_res.left_duty, r_res.right_duty};

    `OADC_ASSERT_NOW(a_no_overwrite, r_out_valid && !i_m_axis_tready, !o_s_axis_tready, "input taken while result stalled")
    `OADC_ASSERT_NEXT(a_result_follows, in_xfer, r_out_valid, "no result after an input transfer")
    `OADC_ASSERT_NOW(a_stop_is_off, r_out_valid && r_res.phase == PH_STOP, r_res.drive_pins == PINS_OFF && r_res.right_duty == 8'd0 && r_res.left_duty == 8'd0, "motors not off while stopped")
    `OADC_ASSERT_NOW(a_rev_pins, r_out_valid && r_res.phase == PH_REV, r_res.drive_pins == PINS_REV, "wrong pins while reversing")

endmodule

### tb/tb_top.sv
// self-checking testbench for obstacle_avoidance_drive_controller: directed and random
// sensor ticks against a built-in model of the avoidance sequence
// depends on oadc_pkg and the obstacle_avoidance_drive_controller top level
`timescale 1ns / 1ps

module tb_top;
    import oadc_pkg::*;

    // spare register indexes, writes there must be ignored
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 190;

    typedef enum logic [1:0] {OP_TICK, OP_CFG, OP_DRAIN} t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [39:0] tick;
        logic [2:0]  idx;
        logic [9:0]  val;
    } t_op;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // front[9:0], rear[19:10], left[29:20], right[39:30]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;        // right_duty[7:0], left_duty[15:8],
                                        // drive_pins[19:16], phase[22:20], zero[23]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    obstacle_avoidance_drive_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // pending stimulus and expected drive outputs
    t_op     pending_ops[$];
    t_result expected_drive_q[$];
    int      drive_mismatches = 0;
    bit      no_idle = 1'b0;

    // model of the controller
    t_cfg        cfg_model;
    logic [2:0]  drive_phase = PH_CRUISE;
    logic [3:0]  tick_cnt = '0;
    logic        motors_running = 1'b0;
    logic        fwd_applied = 1'b0;
    logic [3:0]  pin_state = PINS_OFF;
    logic [15:0] duty_state = '0;

    // load the duty pair for the current speed level, out-of-range levels keep it
    function automatic void power_up();
        case (cfg_model.speed_level)
            3'd1: duty_state = {8'd210, 8'd170};
            3'd2: duty_state = {8'd219, 8'd177};
            3'd3: duty_state = {8'd225, 8'd207};
            3'd4: duty_state = {8'd240, 8'd194};
            3'd5: duty_state = {8'd255, 8'd207};
            default: ;
        endcase
        motors_running = 1'b1;
    endfunction

    // 4-bit tick counter, a limit of zero is met after sixteen ticks
    function automatic bit count_reached(input logic [3:0] lim);
        tick_cnt = tick_cnt + 4'd1;
        if (tick_cnt == lim) begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the model by one tick and queue the output it gives
    function automatic void predict_drive_tick(input logic [39:0] d);
        logic [9:0] front_s, rear_s, left_s, right_s;
        t_result    r;
        front_s = d[9:0];
        rear_s  = d[19:10];
        left_s  = d[29:20];
        right_s = d[39:30];
        case (drive_phase)
            PH_STOP: begin
                if (count_reached(cfg_model.stop_ticks)) drive_phase = PH_REAR;
            end
            PH_REAR: begin
                if (rear_s < cfg_model.front_threshold) begin
                    power_up();
                    pin_state = PINS_REV;
                    drive_phase = PH_REV;
                end else begin
                    drive_phase = PH_CHOOSE;
                end
            end
            PH_REV: begin
                if (rear_s < cfg_model.front_threshold) begin
                    if (count_reached(cfg_model.reverse_ticks)) drive_phase = PH_CHOOSE;
                end else begin
                    tick_cnt = '0;
                    drive_phase = PH_CHOOSE;
                end
            end
            PH_CHOOSE: begin
                if (left_s <= right_s && left_s < cfg_model.side_threshold) begin
                    pin_state = PINS_LEFT;
                    drive_phase = PH_LEFT;
                end else if (right_s < cfg_model.side_threshold) begin
                    pin_state = PINS_RIGHT;
                    drive_phase = PH_RIGHT;
                end else begin
                    drive_phase = PH_CRUISE;
                end
            end
            PH_LEFT, PH_RIGHT: begin
                if (count_reached(cfg_model.turn_ticks)) drive_phase = PH_CRUISE;
            end
            default: begin
                drive_phase = PH_CRUISE;
                if (front_s < cfg_model.front_threshold) begin
                    if (!motors_running) power_up();
                    if (!fwd_applied) begin
                        pin_state = PINS_FWD;
                        fwd_applied = 1'b1;
                    end
                end else begin
                    duty_state = '0;
                    pin_state = PINS_OFF;
                    motors_running = 1'b0;
                    fwd_applied = 1'b0;
                    drive_phase = PH_STOP;
                end
            end
        endcase
        r.right_duty = duty_state[15:8];
        r.left_duty  = duty_state[7:0];
        r.drive_pins = pin_state;
        r.phase      = drive_phase;
        expected_drive_q.push_back(r);
    endfunction

    function automatic void apply_cfg(input logic [2:0] idx, input logic [9:0] val);
        case (idx)
            REG_SPEED_LEVEL:  cfg_model.speed_level = val[2:0];
            REG_FRONT_THRESH: cfg_model.front_threshold = val;
            REG_SIDE_THRESH:  cfg_model.side_threshold = val;
            REG_STOP_TICKS:   cfg_model.stop_ticks = val[3:0];
            REG_REV_TICKS:    cfg_model.reverse_ticks = val[3:0];
            REG_TURN_TICKS:   cfg_model.turn_ticks = val[3:0];
            default: ;
        endcase
    endfunction

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // distance sample biased around a threshold
    function automatic logic [9:0] pick_sample(input logic [9:0] thr, input int clear_pct);
        int r;
        r = $urandom_range(99, 0);
        if (r >= 95) return ($urandom_range(1, 0) == 1) ? 10'h3FF : 10'h000;
        if (r >= 88) begin
            if (thr == 0) return 10'h000;
            return thr - 10'd1 + 10'($urandom_range(1, 0));
        end
        if (r < clear_pct && thr != 0) return 10'($urandom_range(thr - 1, 0));
        return 10'($urandom_range(1023, thr));
    endfunction

    function automatic void compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            drive_mismatches++;
        end
    endfunction

    // input driver: sensor ticks, register writes and drain points
    int  send_gap = 0;
    bit  tick_hold, cfg_hold, next_tvalid, next_cvalid;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
            send_gap = 0;
        end else begin
            tick_hold = i_s_axis_tvalid && !o_s_axis_tready;
            cfg_hold = i_cfg_valid && !o_cfg_ready;
            if (i_s_axis_tvalid && o_s_axis_tready) predict_drive_tick(i_s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) apply_cfg(i_cfg_index, i_cfg_data);
            next_tvalid = tick_hold;
            next_cvalid = cfg_hold;
            if (!tick_hold && !cfg_hold) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0) begin
                    case (pending_ops[0].kind)
                        OP_TICK: begin
                            next_tvalid = 1'b1;
                            i_s_axis_tdata <= pending_ops[0].tick;
                            void'(pending_ops.pop_front());
                            send_gap = pick_gap();
                        end
                        OP_CFG: begin
                            // register writes only once all outputs are back
                            if (expected_drive_q.size() == 0) begin
                                next_cvalid = 1'b1;
                                i_cfg_index <= pending_ops[0].idx;
                                i_cfg_data <= pending_ops[0].val;
                                void'(pending_ops.pop_front());
                            end
                        end
                        default: begin
                            if (expected_drive_q.size() == 0) void'(pending_ops.pop_front());
                        end
                    endcase
                end
            end
            i_s_axis_tvalid <= next_tvalid;
            i_cfg_valid <= next_cvalid;
        end
    end

    // output monitor with random back-pressure
    int      stall_left = 0;
    t_result exp_r;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_drive_q.size() == 0) begin
                    $display("%0t: unexpected output, expected none, actual %h",
                             $time, o_m_axis_tdata);
                    drive_mismatches++;
                end else begin
                    exp_r = expected_drive_q.pop_front();
                    compare_field("right_duty", exp_r.right_duty, o_m_axis_tdata[7:0]);
                    compare_field("left_duty", exp_r.left_duty, o_m_axis_tdata[15:8]);
                    compare_field("drive_pins", exp_r.drive_pins, o_m_axis_tdata[19:16]);
                    compare_field("phase", exp_r.phase, o_m_axis_tdata[22:20]);
                    compare_field("pad bit", 0, o_m_axis_tdata[23]);
                end
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("obstacle_avoidance_drive_controller verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // stimulus helpers
    task automatic push_tick(input logic [9:0] f, input logic [9:0] r,
                             input logic [9:0] l, input logic [9:0] rt);
        t_op op;
        op = '0;
        op.kind = OP_TICK;
        op.tick = {rt, l, r, f};
        pending_ops.push_back(op);
    endtask

    task automatic push_cfg(input logic [2:0] idx, input logic [9:0] val);
        t_op op;
        op = '0;
        op.kind = OP_CFG;
        op.idx = idx;
        op.val = val;
        pending_ops.push_back(op);
    endtask

    task automatic push_drain();
        t_op op;
        op = '0;
        op.kind = OP_DRAIN;
        pending_ops.push_back(op);
    endtask

    task automatic wait_idle();
        while (pending_ops.size() != 0 || expected_drive_q.size() != 0 ||
               i_s_axis_tvalid || i_cfg_valid)
            @(posedge i_clk);
    endtask

    // write all registers, unused upper data bits randomized
    task automatic write_all(input int spd, input int fthr, input int sthr,
                             input int stp, input int rev, input int trn);
        push_cfg(REG_SPEED_LEVEL, {7'($urandom()), 3'(spd)});
        push_cfg(REG_FRONT_THRESH, 10'(fthr));
        push_cfg(REG_SIDE_THRESH, 10'(sthr));
        push_cfg(REG_STOP_TICKS, {6'($urandom()), 4'(stp)});
        push_cfg(REG_REV_TICKS, {6'($urandom()), 4'(rev)});
        push_cfg(REG_TURN_TICKS, {6'($urandom()), 4'(trn)});
    endtask

    // random ticks biased so the full avoidance sequence keeps recurring
    task automatic random_ticks(input int n, input logic [9:0] fthr, input logic [9:0] sthr);
        logic [9:0] l;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2 || $urandom_range(99, 0) == 0) push_drain();
            l = pick_sample(sthr, 50);
            push_tick(pick_sample(fthr, 75), pick_sample(fthr, 60), l,
                      ($urandom_range(9, 0) == 0) ? l : pick_sample(sthr, 50));
        end
    endtask

    int spd, fthr, sthr, stp, rev, trn;

    initial begin
        cfg_model.speed_level = 3'd3;
        cfg_model.front_threshold = 10'd500;
        cfg_model.side_threshold = 10'd510;
        cfg_model.stop_ticks = 4'd7;
        cfg_model.reverse_ticks = 4'd7;
        cfg_model.turn_ticks = 4'd5;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short limits, walk every phase and both turn directions
        push_cfg(REG_SPARE_6, 10'h3FF);
        write_all(3, 500, 510, 1, 2, 1);
        push_cfg(REG_SPARE_7, 10'h000);
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);              // start forward
        push_tick(10'd499, 10'h3FF, 10'h3FF, 10'h3FF);      // just clear
        push_tick(10'd500, 10'd0, 10'd0, 10'd0);            // obstacle at threshold
        push_tick(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);      // stop done
        push_tick(10'd0, 10'd0, 10'h3FF, 10'd0);            // rear clear, reverse
        push_tick(10'd0, 10'h3FF, 10'd0, 10'd0);            // rear blocked early
        push_tick(10'd0, 10'd0, 10'd100, 10'd100);          // equal sides, go left
        push_tick(10'h3FF, 10'd0, 10'd0, 10'd0);            // turn done
        push_tick(10'h3FF, 10'd0, 10'd0, 10'd0);            // stop again
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);
        push_tick(10'd0, 10'h3FF, 10'd0, 10'd0);            // rear blocked, no reverse
        push_tick(10'd0, 10'd0, 10'd600, 10'd200);          // right turn, motors off
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);              // forward again
        push_tick(10'h3FF, 10'd0, 10'd0, 10'd0);
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);              // reverse full length
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);
        push_tick(10'd0, 10'd0, 10'd509, 10'd510);          // left clear by one
        push_tick(10'd0, 10'd0, 10'h3FF, 10'h3FF);
        wait_idle();
        // speed level out of range keeps the duty pair
        push_cfg(REG_SPEED_LEVEL, 10'd0);
        push_tick(10'h3FF, 10'd0, 10'd0, 10'd0);
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);
        push_tick(10'd0, 10'd0, 10'd0, 10'd0);
        wait_idle();

        // random phases over several register settings
        for (int ph = 0; ph < 10; ph++) begin
            spd = ($urandom_range(4, 0) == 0) ? $urandom_range(7, 0) : $urandom_range(5, 1);
            fthr = $urandom_range(900, 100);
            sthr = $urandom_range(900, 100);
            stp = $urandom_range(15, 0);
            rev = $urandom_range(15, 0);
            trn = $urandom_range(15, 0);
            case (ph)
                0: begin spd = 3; fthr = 500; sthr = 510; stp = 7; rev = 7; trn = 5; end
                1: begin spd = 1; fthr = 1023; sthr = 1023; stp = 15; rev = 15; trn = 15; end
                2: begin spd = 5; fthr = 0; sthr = 0; stp = 1; rev = 1; trn = 1; end
                3: begin spd = 0; stp = 0; rev = 0; trn = 0; end
                4: spd = 7;
                default: ;
            endcase
            no_idle = (ph == 6);
            write_all(spd, fthr, sthr, stp, rev, trn);
            random_ticks(PHASE_ITEMS, 10'(fthr), 10'(sthr));
            wait_idle();
        end
        no_idle = 1'b0;

        repeat (10) @(posedge i_clk);
        if (expected_drive_q.size() != 0) begin
            $display("%0t: outputs missing, expected %0d more, actual 0",
                     $time, expected_drive_q.size());
            drive_mismatches++;
        end
        if (drive_mismatches == 0) begin
            $display("obstacle_avoidance_drive_controller verification clean");
        end else begin
            $display("obstacle_avoidance_drive_controller verification failed");
        end
        $finish;
    end

endmodule
